// ----- rtl/pl_pkg.sv -----
// shared types, constants and helper functions for the positional list engine
package pl_pkg;

  localparam int CMD_W      = 2;
  localparam int POS_W      = 9;
  localparam int ENTRY_W    = 64;
  localparam int STATUS_W   = 2;
  localparam int LENGTH_W   = 9;
  localparam int CAPACITY_D = 256;
  localparam int TREE_FAN   = 8;
  localparam int TREE_SHIFT = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic             ins;
    logic             del;
    logic [POS_W-1:0] idx;
    logic             rd;
    logic [POS_W-1:0] rd_idx;
  } cell_ctl_t;

  // nodes left after k reduction levels of n leaves
  function automatic int tree_nodes(input int n, input int k);
    int r;
    r = n;
    for (int i = 0; i < k; i++) begin
      r = (r + TREE_FAN - 1) >> TREE_SHIFT;
    end
    return r;
  endfunction

  // number of registered reduction levels down to one node
  function automatic int tree_levels(input int n);
    int r;
    int l;
    r = n;
    l = 0;
    while (r > 1 || l == 0) begin
      r = (r + TREE_FAN - 1) >> TREE_SHIFT;
      l++;
    end
    return l;
  endfunction

endpackage

// ----- rtl/pl_if.sv -----
// request and response channel interfaces of the positional list engine
interface pl_req_if;
  logic                      valid;
  logic                      ready;
  logic [pl_pkg::CMD_W-1:0]   cmd;
  logic [pl_pkg::POS_W-1:0]   position;
  logic [pl_pkg::ENTRY_W-1:0] entry_value;

  modport source(output valid, cmd, position, entry_value, input ready);
  modport sink(input valid, cmd, position, entry_value, output ready);
endinterface

interface pl_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [pl_pkg::STATUS_W-1:0] status;
  logic [pl_pkg::ENTRY_W-1:0]  read_value;
  logic [pl_pkg::LENGTH_W-1:0] list_length;
  logic                        list_empty;

  modport source(output valid, status, read_value, list_length, list_empty, input ready);
  modport sink(input valid, status, read_value, list_length, list_empty, output ready);
endinterface

// ----- rtl/positional_list_engine_unit.sv -----
// top level of the positional list engine: cell row, read tree and control
// Usage:
//   req carries cmd, position and entry_value; rsp returns status, read_value,
//   list_length and list_empty, one response for every request.
//   Both channels move a request on a clock edge where valid and ready are high.
//   Entries sit in a row of CAPACITY cells; insert and delete shift the cells
//   from the given position on by one place at the edge the request is taken,
//   clear only zeroes the length.
//   Flow: the request edge registers the read select, the chosen cell then
//   passes the L = ceil(log8(CAPACITY)) registered levels of the read tree (3 at
//   256 entries), and the response is loaded after them; a new request is taken
//   only once the response of the last one has been loaded. The read tree is
//   what sets the delay: it gathers the chosen cell over L registered levels.
//   The output register holds a finished response while rsp.ready is low;
//   the next request is still taken, and its response waits behind the first.
//   Reset (rst, synchronous) empties the list and drops any pending response;
//   cell contents are undefined until written and never reach the output.
module positional_list_engine_unit #(
  parameter int CAPACITY = pl_pkg::CAPACITY_D
) (
  input logic        clk,
  input logic        rst,
  pl_req_if.sink     req,
  pl_rsp_if.source   rsp
);
  import pl_pkg::*;

  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int PW     = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam int LEVELS = tree_levels(CAPACITY);
  localparam int WW     = $clog2(LEVELS + 1);

  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic                pending;
  logic [WW-1:0]       wait_cnt;
  status_t             pend_status;
  logic [CW-1:0]       pend_count;
  cell_ctl_t           ctl;
  logic                rd_sel;
  logic [POS_W-1:0]    rd_idx;

  logic                fire;
  cmd_t                cmd;
  logic [PW-1:0]       pos_w;
  logic [PW-1:0]       cnt_w;
  logic                pos_nz;
  logic                ins_pos_ok;
  logic                pos_ok;
  logic                full;
  status_t             status_next;
  logic                ins_do;
  logic                del_do;
  logic                rd_do;
  logic [POS_W-1:0]    idx;
  logic                done;

  logic [ENTRY_W-1:0]  value [CAPACITY];
  logic [ENTRY_W-1:0]  tap   [CAPACITY];
  logic [ENTRY_W-1:0]  tree_out;

  assign req.ready = !pending;
  assign fire      = req.valid && req.ready;
  assign cmd       = cmd_t'(req.cmd);

  assign pos_w      = PW'(req.position);
  assign cnt_w      = PW'(count);
  assign pos_nz     = (req.position != '0);
  assign ins_pos_ok = pos_nz && (pos_w <= cnt_w + PW'(1));
  assign pos_ok     = pos_nz && (pos_w <= cnt_w);
  assign full       = (count == CW'(CAPACITY));
  assign idx        = req.position - POS_W'(1);

  always_comb begin
    status_next = ST_OK;
    ins_do      = 1'b0;
    del_do      = 1'b0;
    rd_do       = 1'b0;
    count_next  = count;
    case (cmd)
      CMD_INSERT: begin
        if (!ins_pos_ok) begin
          status_next = ST_RANGE;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          ins_do     = 1'b1;
          count_next = count + CW'(1);
        end
      end
      CMD_DELETE: begin
        if (!pos_ok) begin
          status_next = ST_RANGE;
        end else begin
          del_do     = 1'b1;
          count_next = count - CW'(1);
        end
      end
      CMD_READ: begin
        if (!pos_ok) begin
          status_next = ST_RANGE;
        end else begin
          rd_do = 1'b1;
        end
      end
      CMD_CLEAR: begin
        count_next = '0;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  assign ctl.ins    = fire && ins_do;
  assign ctl.del    = fire && del_do;
  assign ctl.idx    = idx;
  assign ctl.rd     = rd_sel;
  assign ctl.rd_idx = rd_idx;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ENTRY_W-1:0] left_value;
    logic [ENTRY_W-1:0] right_value;
    if (i == 0) begin : g_first
      assign left_value = '0;
    end else begin : g_mid_l
      assign left_value = value[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_value = '0;
    end else begin : g_mid_r
      assign right_value = value[i+1];
    end
    pl_cell #(
      .INDEX(i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .left_value (left_value),
      .right_value(right_value),
      .new_value  (req.entry_value),
      .value      (value[i]),
      .tap        (tap[i])
    );
  end

  pl_or_tree #(
    .N(CAPACITY)
  ) u_tree (
    .clk   (clk),
    .leaf  (tap),
    .result(tree_out)
  );

  assign done = pending && (wait_cnt == '0) && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pending   <= 1'b0;
      wait_cnt  <= '0;
      rd_sel    <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (fire) begin
        count    <= count_next;
        pending  <= 1'b1;
        wait_cnt <= WW'(LEVELS);
        rd_sel   <= rd_do;
      end else if (pending && wait_cnt != '0) begin
        wait_cnt <= wait_cnt - WW'(1);
      end
      if (done) begin
        pending   <= 1'b0;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pend_status <= status_next;
      pend_count  <= count_next;
      rd_idx      <= idx;
    end
    if (done) begin
      rsp.status      <= pend_status;
      rsp.read_value  <= tree_out;
      rsp.list_length <= LENGTH_W'(pend_count);
      rsp.list_empty  <= (pend_count == '0);
    end
  end

endmodule

// ----- rtl/pl_cell.sv -----
// one list cell: holds an entry and shifts it to or from its neighbours
module pl_cell #(
  parameter int INDEX = 0
) (
  input  logic                      clk,
  input  pl_pkg::cell_ctl_t         ctl,
  input  logic [pl_pkg::ENTRY_W-1:0] left_value,
  input  logic [pl_pkg::ENTRY_W-1:0] right_value,
  input  logic [pl_pkg::ENTRY_W-1:0] new_value,
  output logic [pl_pkg::ENTRY_W-1:0] value,
  output logic [pl_pkg::ENTRY_W-1:0] tap
);
  import pl_pkg::*;

  logic                is_at;
  logic                is_after;
  logic                rd_at;
  logic [ENTRY_W-1:0]  value_next;

  assign is_at    = (INDEX == int'(ctl.idx));
  assign is_after = (INDEX > int'(ctl.idx));
  assign rd_at    = ctl.rd && (INDEX == int'(ctl.rd_idx));

  always_comb begin
    value_next = value;
    if (ctl.ins && is_after) begin
      value_next = left_value;
    end else if (ctl.ins && is_at) begin
      value_next = new_value;
    end else if (ctl.del && (is_at || is_after)) begin
      value_next = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

  assign tap = rd_at ? value : '0;

endmodule

// ----- rtl/pl_or_tree.sv -----
// registered or-reduction tree that gathers the selected cell onto one word
module pl_or_tree #(
  parameter int N = pl_pkg::CAPACITY_D
) (
  input  logic                       clk,
  input  logic [pl_pkg::ENTRY_W-1:0] leaf [N],
  output logic [pl_pkg::ENTRY_W-1:0] result
);
  import pl_pkg::*;

  localparam int LEVELS = tree_levels(N);

  logic [ENTRY_W-1:0] node [1:LEVELS][0:N-1];

  for (genvar k = 1; k <= LEVELS; k++) begin : g_level
    localparam int PREV = tree_nodes(N, k - 1);
    localparam int CUR  = tree_nodes(N, k);
    for (genvar j = 0; j < CUR; j++) begin : g_node
      logic [ENTRY_W-1:0] acc;
      if (k == 1) begin : g_from_leaf
        always_comb begin
          acc = '0;
          for (int m = 0; m < TREE_FAN; m++) begin
            if (j * TREE_FAN + m < PREV) begin
              acc = acc | leaf[j * TREE_FAN + m];
            end
          end
        end
      end else begin : g_from_node
        always_comb begin
          acc = '0;
          for (int m = 0; m < TREE_FAN; m++) begin
            if (j * TREE_FAN + m < PREV) begin
              acc = acc | node[k-1][j * TREE_FAN + m];
            end
          end
        end
      end
      always_ff @(posedge clk) begin
        node[k][j] <= acc;
      end
    end
  end

  assign result = node[LEVELS][0];

endmodule
